>>> design/rbfe_pkg.sv
// Shared types and constants for the RGB brightness fade engine.
`timescale 1ns / 1ps

package rbfe_pkg;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned NumChan    = 4;
  localparam int unsigned ChanIdxW   = 2;
  localparam int unsigned MsW        = 16;
  localparam int unsigned ProgW      = 7;
  localparam int unsigned DividendW  = 23;
  localparam int unsigned ProdW      = 28;
  localparam int unsigned RecipShift = 19;

  localparam logic [ProgW-1:0] FullProgress = 7'd100;
  localparam logic [MsW-1:0]   ResetFadeMs  = 16'd400;
  localparam logic [12:0]      RecipHundred = 13'd5243;
  localparam logic [ChanW-1:0] ChanFull     = 8'd255;
  localparam logic [MsW-1:0]   MsMax        = 16'hFFFF;

  localparam logic ModeTick = 1'b0;
  localparam logic ModeCmd  = 1'b1;

  localparam logic RegDefaultFade = 1'b0;

  localparam logic [ChanIdxW-1:0] ChRed   = 2'd0;
  localparam logic [ChanIdxW-1:0] ChGreen = 2'd1;
  localparam logic [ChanIdxW-1:0] ChBlue  = 2'd2;
  localparam logic [ChanIdxW-1:0] ChLevel = 2'd3;

  typedef struct packed {
    logic       mode;
    logic       has_power;
    logic       power_on;
    logic       has_color;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       has_level;
    logic [7:0] level_in;
    logic       has_duration;
    logic [15:0] duration_ms;
  } rbfe_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] level_out;
    logic       lamp_on;
    logic       fade_done;
  } rbfe_out_t;

  typedef struct packed {
    logic             start;
    logic [DividendW-1:0] dividend;
    logic [MsW-1:0]   divisor;
  } rbfe_div_req_t;

  typedef struct packed {
    logic             done;
    logic [ProgW-1:0] quotient;
  } rbfe_div_rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StScale,
    StDivStart,
    StDivWait,
    StMul,
    StRecip,
    StApply,
    StEmit
  } rbfe_state_e;

endpackage

>>> design/rbfe_div.sv
// Iterative restoring divider producing the 7-bit fade progress quotient.
`timescale 1ns / 1ps

module rbfe_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rbfe_pkg::rbfe_div_req_t req_i,
  output rbfe_pkg::rbfe_div_rsp_t rsp_o
);

  logic [rbfe_pkg::MsW-1:0]   rem_q, rem_d;
  logic [rbfe_pkg::ProgW-1:0] lo_q, lo_d;
  logic [2:0]                 cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [rbfe_pkg::MsW:0]     shifted;
  logic [rbfe_pkg::MsW:0]     trial;
  logic                       fits;

  assign shifted = {rem_q, lo_q[rbfe_pkg::ProgW-1]};
  assign fits    = shifted >= {1'b0, req_i.divisor};
  assign trial   = shifted - {1'b0, req_i.divisor};

  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.dividend[rbfe_pkg::DividendW-1:rbfe_pkg::ProgW];
      lo_d   = req_i.dividend[rbfe_pkg::ProgW-1:0];
      cnt_d  = 3'(rbfe_pkg::ProgW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = trial[rbfe_pkg::MsW-1:0];
      end else begin
        rem_d = shifted[rbfe_pkg::MsW-1:0];
      end
      lo_d  = {lo_q[rbfe_pkg::ProgW-2:0], fits};
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = lo_q;

endmodule

>>> design/rgb_brightness_fade_engine.sv
// Top level of the RGB brightness fade engine: sequencer, state and shared multiplier.
`timescale 1ns / 1ps

// Usage:
// Input channel (in_valid_i/in_ready_o/in_data_i) takes commands and 1 ms ticks.
// A command updates goal, start snapshot and fade length in the accept cycle,
// gives no result, and leaves the block ready in the next cycle.
// A tick outside a fade is dropped with no result. A tick during a fade runs
// the sequencer: scale elapsed time by 100, a 7-step divide for progress
// (skipped when the fade is over or has zero length), then three steps per
// channel on the shared 16x16 multiplier (delta times progress, times the
// reciprocal of 100, apply). The result is loaded into the output register
// from the emit state, and in_ready_o returns in the same cycle as out_valid_o
// rises; no new item is taken while a tick is in progress.
// Output channel (out_valid_o/out_ready_i/out_data_o) holds one result in a
// register; the block accepts the next item while it waits. A further tick
// holds in its last step until the output register is free.
// APB port: default_fade_ms at byte address 0, pready_o always high.
// Reset: all channels 255, lamp off, no fade, default fade 400 ms.
module rgb_brightness_fade_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rbfe_pkg::rbfe_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rbfe_pkg::rbfe_out_t out_data_o,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [2:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  output logic [31:0]         prdata_o,
  output logic                pready_o
);

  rbfe_pkg::rbfe_state_e state_q, state_d;

  logic [rbfe_pkg::ChanW-1:0] cur_q   [rbfe_pkg::NumChan];
  logic [rbfe_pkg::ChanW-1:0] start_q [rbfe_pkg::NumChan];
  logic [rbfe_pkg::ChanW-1:0] goal_q  [rbfe_pkg::NumChan];
  logic [rbfe_pkg::ChanW-1:0] remembered_q;
  logic [rbfe_pkg::MsW-1:0]   elapsed_q;
  logic [rbfe_pkg::MsW-1:0]   fade_len_q;
  logic [rbfe_pkg::MsW-1:0]   default_fade_q;
  logic                       fading_q;
  logic                       power_q;
  logic [rbfe_pkg::ChanIdxW-1:0] ch_q;
  logic [rbfe_pkg::ProgW-1:0] progress_q;
  logic [rbfe_pkg::ProdW-1:0] prod_q;
  logic                       out_valid_q;
  rbfe_pkg::rbfe_out_t        out_q;

  logic                       in_fire;
  logic                       tick_go;
  logic                       cfg_we;
  logic                       full_progress;
  logic                       emit_go;
  logic [rbfe_pkg::MsW-1:0]   mul_a, mul_b;
  logic [31:0]                mul_res;
  logic                       neg;
  logic [rbfe_pkg::ChanW-1:0] mag;
  logic [rbfe_pkg::ChanW-1:0] step;
  rbfe_pkg::rbfe_div_req_t    div_req;
  rbfe_pkg::rbfe_div_rsp_t    div_rsp;

  assign in_fire  = in_valid_i && in_ready_o;
  assign tick_go  = in_fire && (in_data_i.mode == rbfe_pkg::ModeTick) && fading_q;
  assign cfg_we   = psel_i && penable_i && pwrite_i && pready_o;
  assign full_progress = (fade_len_q == '0) || (elapsed_q >= fade_len_q);
  assign emit_go  = !out_valid_q || out_ready_i;

  assign neg  = goal_q[ch_q] < start_q[ch_q];
  assign mag  = neg ? (start_q[ch_q] - goal_q[ch_q]) : (goal_q[ch_q] - start_q[ch_q]);
  assign step = prod_q[rbfe_pkg::RecipShift +: rbfe_pkg::ChanW];
  assign mul_res = mul_a * mul_b;

  rbfe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      rbfe_pkg::StIdle: begin
        if (tick_go) begin
          state_d = rbfe_pkg::StScale;
        end
      end
      rbfe_pkg::StScale: begin
        if (full_progress) begin
          state_d = rbfe_pkg::StMul;
        end else begin
          state_d = rbfe_pkg::StDivStart;
        end
      end
      rbfe_pkg::StDivStart: state_d = rbfe_pkg::StDivWait;
      rbfe_pkg::StDivWait: begin
        if (div_rsp.done) begin
          state_d = rbfe_pkg::StMul;
        end
      end
      rbfe_pkg::StMul:   state_d = rbfe_pkg::StRecip;
      rbfe_pkg::StRecip: state_d = rbfe_pkg::StApply;
      rbfe_pkg::StApply: begin
        if (ch_q == rbfe_pkg::ChLevel) begin
          state_d = rbfe_pkg::StEmit;
        end else begin
          state_d = rbfe_pkg::StMul;
        end
      end
      rbfe_pkg::StEmit: begin
        if (emit_go) begin
          state_d = rbfe_pkg::StIdle;
        end
      end
      default: state_d = rbfe_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q[rbfe_pkg::DividendW-1:0];
    div_req.divisor  = fade_len_q;
    case (state_q)
      rbfe_pkg::StIdle: in_ready_o = 1'b1;
      rbfe_pkg::StScale: begin
        mul_a = elapsed_q;
        mul_b = {9'd0, rbfe_pkg::FullProgress};
      end
      rbfe_pkg::StDivStart: div_req.start = 1'b1;
      rbfe_pkg::StMul: begin
        mul_a = {8'd0, mag};
        mul_b = {9'd0, progress_q};
      end
      rbfe_pkg::StRecip: begin
        mul_a = prod_q[rbfe_pkg::MsW-1:0];
        mul_b = {3'd0, rbfe_pkg::RecipHundred};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbfe_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rbfe_pkg::NumChan; i++) begin
        cur_q[i]   <= rbfe_pkg::ChanFull;
        start_q[i] <= rbfe_pkg::ChanFull;
        goal_q[i]  <= rbfe_pkg::ChanFull;
      end
      remembered_q   <= rbfe_pkg::ChanFull;
      elapsed_q      <= '0;
      fade_len_q     <= rbfe_pkg::ResetFadeMs;
      default_fade_q <= rbfe_pkg::ResetFadeMs;
      fading_q       <= 1'b0;
      power_q        <= 1'b0;
      ch_q           <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we && (paddr_i[2] == rbfe_pkg::RegDefaultFade)) begin
        default_fade_q <= pwdata_i[rbfe_pkg::MsW-1:0];
      end
      if ((state_q == rbfe_pkg::StEmit) && emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        rbfe_pkg::StIdle: begin
          if (in_fire && (in_data_i.mode == rbfe_pkg::ModeCmd)) begin
            if (in_data_i.has_power) begin
              power_q <= in_data_i.power_on;
            end
            if (in_data_i.has_color) begin
              goal_q[rbfe_pkg::ChRed]    <= in_data_i.red_in;
              goal_q[rbfe_pkg::ChGreen]  <= in_data_i.green_in;
              goal_q[rbfe_pkg::ChBlue]   <= in_data_i.blue_in;
              start_q[rbfe_pkg::ChRed]   <= cur_q[rbfe_pkg::ChRed];
              start_q[rbfe_pkg::ChGreen] <= cur_q[rbfe_pkg::ChGreen];
              start_q[rbfe_pkg::ChBlue]  <= cur_q[rbfe_pkg::ChBlue];
            end
            if (in_data_i.has_level) begin
              remembered_q              <= in_data_i.level_in;
              goal_q[rbfe_pkg::ChLevel] <= in_data_i.level_in;
            end else if (in_data_i.has_power) begin
              goal_q[rbfe_pkg::ChLevel] <= in_data_i.power_on ? remembered_q : '0;
            end
            if (in_data_i.has_power || in_data_i.has_level) begin
              start_q[rbfe_pkg::ChLevel] <= cur_q[rbfe_pkg::ChLevel];
            end
            elapsed_q  <= '0;
            fading_q   <= 1'b1;
            fade_len_q <= in_data_i.has_duration ? in_data_i.duration_ms : default_fade_q;
          end else if (tick_go) begin
            if (elapsed_q != rbfe_pkg::MsMax) begin
              elapsed_q <= elapsed_q + 16'd1;
            end
          end
        end
        rbfe_pkg::StScale: ch_q <= rbfe_pkg::ChRed;
        rbfe_pkg::StApply: begin
          cur_q[ch_q] <= neg ? (start_q[ch_q] - step) : (start_q[ch_q] + step);
          ch_q        <= ch_q + 2'd1;
        end
        rbfe_pkg::StEmit: begin
          if (emit_go && (progress_q == rbfe_pkg::FullProgress)) begin
            fading_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      rbfe_pkg::StScale: begin
        prod_q <= mul_res[rbfe_pkg::ProdW-1:0];
        if (full_progress) begin
          progress_q <= rbfe_pkg::FullProgress;
        end
      end
      rbfe_pkg::StDivWait: begin
        if (div_rsp.done) begin
          progress_q <= div_rsp.quotient;
        end
      end
      rbfe_pkg::StMul, rbfe_pkg::StRecip: prod_q <= mul_res[rbfe_pkg::ProdW-1:0];
      rbfe_pkg::StEmit: begin
        if (emit_go) begin
          out_q.red_out   <= cur_q[rbfe_pkg::ChRed];
          out_q.green_out <= cur_q[rbfe_pkg::ChGreen];
          out_q.blue_out  <= cur_q[rbfe_pkg::ChBlue];
          out_q.level_out <= cur_q[rbfe_pkg::ChLevel];
          out_q.lamp_on   <= power_q;
          out_q.fade_done <= (progress_q == rbfe_pkg::FullProgress);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready_o    = 1'b1;
  assign prdata_o    = (paddr_i[2] == rbfe_pkg::RegDefaultFade) ?
                       {16'd0, default_fade_q} : 32'd0;

endmodule

>>> design/rbfe_checker.sv
// Port-level checker for the RGB brightness fade engine and its bind.
`timescale 1ns / 1ps

module rbfe_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input rbfe_pkg::rbfe_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rbfe_pkg::rbfe_out_t out_data_o,
  input logic                psel_i,
  input logic                penable_i,
  input logic                pwrite_i,
  input logic [2:0]          paddr_i,
  input logic [31:0]         pwdata_i,
  input logic [31:0]         prdata_o,
  input logic                pready_o
);

  logic cfg_wr0;
  assign cfg_wr0 = psel_i && penable_i && pwrite_i && pready_o &&
                   (paddr_i[2] == rbfe_pkg::RegDefaultFade);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a tick in progress");

  a_cmd_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.mode == rbfe_pkg::ModeCmd)
    |=> in_ready_o && !$rose(out_valid_o))
    else $error("command caused a result or stalled input");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr0 ##1 (paddr_i[2] == rbfe_pkg::RegDefaultFade)
    |-> prdata_o[15:0] == $past(pwdata_i[15:0]))
    else $error("default fade register readback mismatch");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_o)
    else $error("pready low");

endmodule

bind rgb_brightness_fade_engine rbfe_checker u_rbfe_checker (.*);

>>> dv/tb_top.sv
// Testbench for the RGB brightness fade engine: commands and ticks checked against a fade model.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned IdleWait    = 40;
  localparam int unsigned MaxPrint    = 30;
  localparam int          PhaseItems  = 72;
  localparam int unsigned NumPhases   = 5;
  localparam logic [2:0]  AddrDefault = {rbfe_pkg::RegDefaultFade, 2'b00};
  localparam longint      RunLimitNs  = 5_000_000;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  rbfe_pkg::rbfe_in_t   in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rbfe_pkg::rbfe_out_t  out_data;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [2:0]           paddr     = '0;
  logic [31:0]          pwdata    = '0;
  logic [31:0]          prdata;
  logic                 pready;

  logic [rbfe_pkg::ChanW-1:0] cur_m   [rbfe_pkg::NumChan];
  logic [rbfe_pkg::ChanW-1:0] start_m [rbfe_pkg::NumChan];
  logic [rbfe_pkg::ChanW-1:0] goal_m  [rbfe_pkg::NumChan];
  logic [rbfe_pkg::ChanW-1:0] level_mem_m;
  logic [rbfe_pkg::MsW-1:0]   elapsed_m;
  logic [rbfe_pkg::MsW-1:0]   fade_len_m;
  logic [rbfe_pkg::MsW-1:0]   dflt_fade_m;
  logic                       fading_m;
  logic                       power_m;

  rbfe_pkg::rbfe_out_t lamp_frames_q[$];

  int errors        = 0;
  int cmd_count     = 0;
  int frames_seen   = 0;
  int fades_done    = 0;
  int cfg_writes    = 0;
  int useful_items  = 0;
  int burst_left    = 0;
  int stall_mode    = 0;
  int stall_ticks   = 0;

  rgb_brightness_fade_engine dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_o    (prdata),
    .pready_o    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RunLimitNs);
    $display("timeout with %0d results outstanding", lamp_frames_q.size());
    $display("FAIL rgb_brightness_fade_engine");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MaxPrint) begin
      $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    end
  endtask

  task automatic model_reset();
    for (int i = 0; i < rbfe_pkg::NumChan; i++) begin
      cur_m[i]   = rbfe_pkg::ChanFull;
      start_m[i] = rbfe_pkg::ChanFull;
      goal_m[i]  = rbfe_pkg::ChanFull;
    end
    level_mem_m = rbfe_pkg::ChanFull;
    elapsed_m   = '0;
    fade_len_m  = rbfe_pkg::ResetFadeMs;
    dflt_fade_m = rbfe_pkg::ResetFadeMs;
    fading_m    = 1'b0;
    power_m     = 1'b0;
  endtask

  function automatic logic [rbfe_pkg::ChanW-1:0] blend_chan(
      input logic [rbfe_pkg::ChanW-1:0] from,
      input logic [rbfe_pkg::ChanW-1:0] to,
      input int unsigned pct);
    int diff;
    int step;
    int sum;
    diff = int'(to) - int'(from);
    step = (diff * int'(pct)) / int'(rbfe_pkg::FullProgress);
    sum  = int'(from) + step;
    return sum[rbfe_pkg::ChanW-1:0];
  endfunction

  task automatic predict_lamp(input rbfe_pkg::rbfe_in_t it);
    int unsigned         pct;
    rbfe_pkg::rbfe_out_t fr;
    if (it.mode == rbfe_pkg::ModeCmd) begin
      cmd_count++;
      useful_items++;
      if (it.has_power) begin
        power_m = it.power_on;
        goal_m[rbfe_pkg::ChLevel]  = it.power_on ? level_mem_m : '0;
        start_m[rbfe_pkg::ChLevel] = cur_m[rbfe_pkg::ChLevel];
      end
      if (it.has_color) begin
        goal_m[rbfe_pkg::ChRed]    = it.red_in;
        goal_m[rbfe_pkg::ChGreen]  = it.green_in;
        goal_m[rbfe_pkg::ChBlue]   = it.blue_in;
        start_m[rbfe_pkg::ChRed]   = cur_m[rbfe_pkg::ChRed];
        start_m[rbfe_pkg::ChGreen] = cur_m[rbfe_pkg::ChGreen];
        start_m[rbfe_pkg::ChBlue]  = cur_m[rbfe_pkg::ChBlue];
      end
      if (it.has_level) begin
        level_mem_m                = it.level_in;
        goal_m[rbfe_pkg::ChLevel]  = it.level_in;
        start_m[rbfe_pkg::ChLevel] = cur_m[rbfe_pkg::ChLevel];
      end
      elapsed_m  = '0;
      fading_m   = 1'b1;
      fade_len_m = it.has_duration ? it.duration_ms : dflt_fade_m;
    end else if (fading_m) begin
      useful_items++;
      if (elapsed_m != rbfe_pkg::MsMax) elapsed_m++;
      if (fade_len_m == '0) begin
        pct = 32'(rbfe_pkg::FullProgress);
      end else begin
        pct = (32'(elapsed_m) * 32'(rbfe_pkg::FullProgress)) / 32'(fade_len_m);
        if (pct > rbfe_pkg::FullProgress) pct = 32'(rbfe_pkg::FullProgress);
      end
      for (int i = 0; i < rbfe_pkg::NumChan; i++) begin
        cur_m[i] = blend_chan(start_m[i], goal_m[i], pct);
      end
      if (pct == rbfe_pkg::FullProgress) begin
        fading_m = 1'b0;
        fades_done++;
      end
      fr.red_out   = cur_m[rbfe_pkg::ChRed];
      fr.green_out = cur_m[rbfe_pkg::ChGreen];
      fr.blue_out  = cur_m[rbfe_pkg::ChBlue];
      fr.level_out = cur_m[rbfe_pkg::ChLevel];
      fr.lamp_on   = power_m;
      fr.fade_done = (pct == rbfe_pkg::FullProgress);
      lamp_frames_q.push_back(fr);
    end
  endtask

  task automatic send_item(input rbfe_pkg::rbfe_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_lamp(it);
    burst_left--;
  endtask

  function automatic rbfe_pkg::rbfe_in_t tick_item();
    logic [63:0]        raw;
    rbfe_pkg::rbfe_in_t it;
    raw = {$urandom, $urandom};
    it  = raw[$bits(rbfe_pkg::rbfe_in_t)-1:0];
    it.mode = rbfe_pkg::ModeTick;
    return it;
  endfunction

  function automatic rbfe_pkg::rbfe_in_t cmd_item(input logic hp, input logic pon,
                                                  input logic hc,
                                                  input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b, input logic hl,
                                                  input logic [7:0] lv, input logic hd,
                                                  input logic [15:0] dur);
    rbfe_pkg::rbfe_in_t it;
    it.mode         = rbfe_pkg::ModeCmd;
    it.has_power    = hp;
    it.power_on     = pon;
    it.has_color    = hc;
    it.red_in       = r;
    it.green_in     = g;
    it.blue_in      = b;
    it.has_level    = hl;
    it.level_in     = lv;
    it.has_duration = hd;
    it.duration_ms  = dur;
    return it;
  endfunction

  function automatic rbfe_pkg::rbfe_in_t random_cmd();
    logic [63:0]        raw;
    rbfe_pkg::rbfe_in_t it;
    int                 pick;
    raw = {$urandom, $urandom};
    it  = raw[$bits(rbfe_pkg::rbfe_in_t)-1:0];
    it.mode = rbfe_pkg::ModeCmd;
    it.has_duration = ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      it.duration_ms = 16'($urandom_range(0, 12));
    end else if (pick < 9) begin
      it.duration_ms = 16'($urandom_range(13, 300));
    end
    return it;
  endfunction

  task automatic send_ticks(input int n);
    repeat (n) send_item(tick_item());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (lamp_frames_q.size() != 0) @(posedge clk);
    repeat (IdleWait) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == AddrDefault) dflt_fade_m = data[rbfe_pkg::MsW-1:0];
    cfg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_default_reg();
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrDefault;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[rbfe_pkg::MsW-1:0] !== dflt_fade_m) begin
      report_mismatch("default_fade_ms readback", got, 32'(dflt_fade_m));
    end
  endtask

  task automatic set_default_fade(input logic [15:0] ms);
    wait_idle();
    apb_write(AddrDefault, 32'(ms));
    @(posedge clk);
    check_default_reg();
  endtask

  always @(posedge clk) begin
    if (stall_ticks == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_ticks = $urandom_range(20, 120);
    end else begin
      stall_ticks--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_ticks < 4);
    endcase
  end

  always @(posedge clk) begin
    rbfe_pkg::rbfe_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (lamp_frames_q.size() == 0) begin
        report_mismatch("result with none pending", 32'(out_data), '0);
      end else begin
        want = lamp_frames_q.pop_front();
        frames_seen++;
        if (out_data.red_out !== want.red_out)
          report_mismatch("red_out", 32'(out_data.red_out), 32'(want.red_out));
        if (out_data.green_out !== want.green_out)
          report_mismatch("green_out", 32'(out_data.green_out), 32'(want.green_out));
        if (out_data.blue_out !== want.blue_out)
          report_mismatch("blue_out", 32'(out_data.blue_out), 32'(want.blue_out));
        if (out_data.level_out !== want.level_out)
          report_mismatch("level_out", 32'(out_data.level_out), 32'(want.level_out));
        if (out_data.lamp_on !== want.lamp_on)
          report_mismatch("lamp_on", 32'(out_data.lamp_on), 32'(want.lamp_on));
        if (out_data.fade_done !== want.fade_done)
          report_mismatch("fade_done", 32'(out_data.fade_done), 32'(want.fade_done));
      end
    end
  end

  task automatic test_reset_values();
    check_default_reg();
    send_item(tick_item());
  endtask

  task automatic test_directed_fades();
    send_item(cmd_item(1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0,
                       16'h0000));
    send_ticks(2);
    send_item(cmd_item(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1,
                       16'h0000));
    send_ticks(2);
    send_item(cmd_item(1'b1, 1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h0A, 1'b1,
                       16'd4));
    send_ticks(5);
    send_item(cmd_item(1'b1, 1'b0, 1'b1, 8'h00, 8'hFF, 8'h00, 1'b1, 8'hC8, 1'b1,
                       16'd3));
    send_ticks(3);
    send_item(cmd_item(1'b1, 1'b1, 1'b1, 8'hFF, 8'h00, 8'hFF, 1'b0, 8'hFF, 1'b1,
                       16'hFFFF));
    send_ticks(1);
    send_item(cmd_item(1'b0, 1'b1, 1'b1, 8'hAA, 8'h55, 8'h0F, 1'b1, 8'hFF, 1'b1,
                       16'd5));
    send_ticks(6);
  endtask

  task automatic test_default_extremes();
    set_default_fade(16'h0000);
    send_item(cmd_item(1'b0, 1'b0, 1'b1, 8'h12, 8'h34, 8'h56, 1'b0, 8'h00, 1'b0,
                       16'hFFFF));
    send_ticks(2);
    set_default_fade(16'hFFFF);
    send_item(cmd_item(1'b1, 1'b1, 1'b1, 8'h00, 8'h80, 8'hFF, 1'b1, 8'h01, 1'b0,
                       16'h0000));
    send_ticks(3);
  endtask

  task automatic test_random_fades();
    logic [15:0]        setting;
    int                 target;
    int                 n;
    bit                 paused;
    rbfe_pkg::rbfe_in_t it;
    logic [63:0]        raw;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: setting = 16'd3;
        1: setting = 16'd0;
        2: setting = 16'hFFFF;
        3: setting = 16'($urandom_range(1, 10));
        default: setting = 16'($urandom_range(0, 16'hFFFF));
      endcase
      set_default_fade(setting);
      target = useful_items + PhaseItems;
      paused = 1'b0;
      while (useful_items < target) begin
        if (!paused && useful_items > target - PhaseItems / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          raw = {$urandom, $urandom};
          it  = raw[$bits(rbfe_pkg::rbfe_in_t)-1:0];
          send_item(it);
        end else begin
          send_item(random_cmd());
          if (fade_len_m <= 12 && $urandom_range(0, 4) != 0) begin
            n = int'(fade_len_m) + 1 + int'($urandom_range(0, 2));
          end else begin
            n = int'($urandom_range(1, 12));
          end
          send_ticks(n);
        end
      end
    end
  endtask

  initial begin
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_directed_fades();
    test_default_extremes();
    test_random_fades();
    wait_idle();
    $display("covered %0d commands and %0d checked frames, %0d fades run to the end",
             cmd_count, frames_seen, fades_done);
    $display("%0d register writes across default fade settings, %0d mismatches",
             cfg_writes, errors);
    if (errors == 0) begin
      $display("PASS rgb_brightness_fade_engine");
    end else begin
      $display("FAIL rgb_brightness_fade_engine");
    end
    $finish;
  end

endmodule
